// ----- rtl/core/mttr_pkg.sv -----
package mttr_pkg;
  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_RANKED    = 64;
  localparam int ADDR_BYTES    = 6;
  localparam int AW  = 8 * ADDR_BYTES;
  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int OCW = $clog2(TABLE_ENTRIES + 1);
  localparam int QD  = 2;

  localparam logic [1:0] CFG_USE_DST  = 2'd0;
  localparam logic [1:0] CFG_TOP_CNT  = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  // command from front to back
  typedef struct packed {
    logic          do_close;
    logic          do_account;
    logic [31:0]   close_start;
    logic [AW-1:0] addr;
    logic [63:0]   add_bytes;
    logic [31:0]   add_pkts;
  } cmd_t;
endpackage

// ----- rtl/core/mttr_ram.sv -----
module mttr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/mttr_front.sv -----
module mttr_front import mttr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        use_dst,
  input  logic [15:0] ivl_sec,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] time_sec,
  input  logic [AW-1:0] src_addr,
  input  logic [AW-1:0] dst_addr,
  input  logic [15:0] frame_len,
  input  logic        sampled,
  input  logic [31:0] rate_mult,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_EMIT} state_t;
  state_t state_r;
  logic [31:0] t_r, rem_r, q_r;
  logic [5:0]  cnt_r;
  logic [15:0] ivl_r;
  logic        samp_r;
  logic [AW-1:0] addr_r;
  logic [15:0] len_r;
  logic [31:0] rate_r;
  logic [63:0] prod_r;
  logic        open_r;
  logic [31:0] start_r;
  logic        emit_close_r, emit_acc_r;
  logic [31:0] close_start_r;
  logic [32:0] rem_sh;
  logic [31:0] aligned;

  // restoring divide, one quotient bit a cycle
  assign rem_sh  = {rem_r, t_r[31]};
  assign aligned = q_r - rem_r;
  assign in_ready = (state_r == S_IDLE);
  assign cmd_valid = (state_r == S_EMIT);
  assign cmd.do_close    = emit_close_r;
  assign cmd.do_account  = emit_acc_r;
  assign cmd.close_start = close_start_r;
  assign cmd.addr        = addr_r;
  assign cmd.add_bytes   = samp_r ? prod_r : {48'd0, len_r};
  assign cmd.add_pkts    = samp_r ? rate_r : 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      open_r  <= 1'b0;
      start_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r    <= time_sec;
            addr_r <= use_dst ? dst_addr : src_addr;
            len_r  <= frame_len;
            samp_r <= sampled;
            rate_r <= rate_mult;
            ivl_r  <= (ivl_sec == 16'd0) ? 16'd1 : ivl_sec;
            rem_r  <= '0;
            q_r    <= time_sec;
            cnt_r  <= '0;
            if (kind) begin
              emit_close_r  <= open_r;
              emit_acc_r    <= 1'b0;
              close_start_r <= start_r;
              open_r        <= 1'b0;
              state_r       <= S_EMIT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // t_r shifts out, remainder builds
          if (rem_sh >= {17'd0, ivl_r}) begin
            rem_r <= 32'(rem_sh - {17'd0, ivl_r});
          end else begin
            rem_r <= rem_sh[31:0];
          end
          t_r   <= {t_r[30:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // t_r is zero now; restore it from q_r
          t_r    <= q_r;
          prod_r <= {32'd0, 16'd0, len_r} * {32'd0, rate_r};
          state_r <= S_EMIT;
          emit_acc_r <= 1'b1;
          if (open_r && aligned > start_r) begin
            emit_close_r  <= 1'b1;
            close_start_r <= start_r;
            start_r       <= aligned;
          end else begin
            emit_close_r <= 1'b0;
            if (!open_r) begin
              start_r <= aligned;
            end
          end
          open_r <= 1'b1;
        end
        S_EMIT: begin
          if (cmd_ready || (!emit_close_r && !emit_acc_r)) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/mttr_queue.sv -----
module mttr_queue import mttr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);
  cmd_t q_r [QD];
  logic [$clog2(QD)-1:0] wp_r, rp_r;
  logic [$clog2(QD):0]   cnt_r;
  logic push, pop;

  assign in_ready  = (cnt_r != ($clog2(QD)+1)'(QD));
  assign out_valid = (cnt_r != '0);
  assign out_cmd   = q_r[rp_r];
  assign push = in_valid && in_ready && (in_cmd.do_close || in_cmd.do_account);
  assign pop  = out_valid && out_ready;

  // hold entries, advance pointers on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wp_r] <= in_cmd;
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + ($clog2(QD)+1)'(push) - ($clog2(QD)+1)'(pop);
    end
  end
endmodule

// ----- rtl/core/mttr_back.sv -----
module mttr_back import mttr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  top_cnt,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] o_start,
  output logic [6:0]  o_rank,
  output logic [AW-1:0] o_addr,
  output logic [63:0] o_bytes,
  output logic [31:0] o_pkts,
  output logic        o_ovf,
  output logic        o_last
);
  typedef enum logic [3:0] {
    B_IDLE, B_LOOK, B_LCMP, B_UPD, B_UPW, B_SCAN, B_SCMP, B_FETCH, B_FWAIT, B_OUT, B_DONE
  } state_t;
  state_t state_r;

  logic [OCW-1:0] occ_r;
  logic           ovf_r;
  logic [TABLE_ENTRIES-1:0] taken_r;
  logic [IW-1:0]  idx_r, best_r;
  logic           have_r;
  logic [63:0]    best_b_r;
  logic [6:0]     rank_r, lim_r;
  logic [31:0]    start_r;
  cmd_t           c_r;

  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [AW-1:0]  a_rd;
  logic [63:0]    b_rd, b_wd;
  logic [31:0]    p_rd, p_wd;
  logic [AW-1:0]  a_wd;
  logic [64:0]    bsum;
  logic [32:0]    psum;
  logic           newent_r;

  mttr_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_addr (
    .clk, .we, .waddr, .wdata(a_wd), .raddr, .rdata(a_rd));
  mttr_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_bytes (
    .clk, .we, .waddr, .wdata(b_wd), .raddr, .rdata(b_rd));
  mttr_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_pkts (
    .clk, .we, .waddr, .wdata(p_wd), .raddr, .rdata(p_rd));

  assign raddr = idx_r;
  assign waddr = idx_r;
  assign we    = (state_r == B_UPW);
  assign a_wd  = c_r.addr;
  assign bsum  = {1'b0, newent_r ? 64'd0 : b_rd} + {1'b0, c_r.add_bytes};
  assign psum  = {1'b0, newent_r ? 32'd0 : p_rd} + {1'b0, c_r.add_pkts};
  assign b_wd  = bsum[64] ? '1 : bsum[63:0];
  assign p_wd  = psum[32] ? '1 : psum[31:0];
  assign cmd_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign o_start = start_r;
  assign o_rank  = rank_r;
  assign o_addr  = a_rd;
  assign o_bytes = b_rd;
  assign o_pkts  = p_rd;
  assign o_ovf   = ovf_r;
  assign o_last  = ((rank_r == lim_r) || ({1'b0, rank_r} == 8'(occ_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      occ_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            c_r     <= cmd;
            idx_r   <= '0;
            start_r <= cmd.close_start;
            if (cmd.do_close) begin
              rank_r  <= 7'd1;
              lim_r   <= (top_cnt == 7'd0) ? 7'd1 :
                         (top_cnt > 7'(MAX_RANKED)) ? 7'(MAX_RANKED) : top_cnt;
              taken_r <= '0;
              state_r <= (occ_r == '0) ? B_DONE : B_SCAN;
              have_r  <= 1'b0;
            end else begin
              state_r <= B_LOOK;
            end
          end
        end
        // linear lookup, each slot read in B_LOOK and compared in B_LCMP
        B_LOOK: begin
          if (OCW'(idx_r) >= occ_r) begin
            if (occ_r == OCW'(TABLE_ENTRIES)) begin
              ovf_r   <= 1'b1;
              state_r <= B_IDLE;
            end else begin
              newent_r <= 1'b1;
              state_r  <= B_UPW;
            end
          end else begin
            state_r <= B_LCMP;
          end
        end
        B_LCMP: begin
          if (a_rd == c_r.addr) begin
            newent_r <= 1'b0;
            state_r  <= B_UPW;
          end else if (OCW'(idx_r) + 1'b1 >= occ_r) begin
            // no match in the table: add a slot, or drop when full
            if (occ_r == OCW'(TABLE_ENTRIES)) begin
              ovf_r   <= 1'b1;
              state_r <= B_IDLE;
            end else begin
              idx_r    <= idx_r + 1'b1;
              newent_r <= 1'b1;
              state_r  <= B_UPW;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= B_LOOK;
          end
        end
        B_UPW: begin
          if (newent_r) begin
            occ_r <= occ_r + 1'b1;
          end
          state_r <= B_IDLE;
        end
        // find max among untaken, lowest slot on ties
        B_SCAN: begin
          state_r <= B_SCMP;
        end
        B_SCMP: begin
          if (!taken_r[idx_r] && (!have_r || b_rd > best_b_r)) begin
            have_r   <= 1'b1;
            best_r   <= idx_r;
            best_b_r <= b_rd;
          end
          if (OCW'(idx_r) + 1'b1 >= occ_r) begin
            state_r <= B_FETCH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= B_SCAN;
          end
        end
        B_FETCH: begin
          if (!taken_r[idx_r] && (!have_r || b_rd > best_b_r)) begin
            idx_r <= idx_r;
          end else begin
            idx_r <= best_r;
          end
          state_r <= B_FWAIT;
        end
        B_FWAIT: begin
          taken_r[idx_r] <= 1'b1;
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            if (o_last) begin
              state_r <= B_DONE;
            end else begin
              rank_r  <= rank_r + 7'd1;
              idx_r   <= '0;
              have_r  <= 1'b0;
              state_r <= B_SCAN;
            end
          end
        end
        B_DONE: begin
          occ_r <= '0;
          ovf_r <= 1'b0;
          state_r <= c_r.do_account ? B_LOOK : B_IDLE;
          idx_r <= '0;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/mac_top_talker_ranker.sv -----
// MAC top-talker ranker.
// in_ channel: one frame or close command per transfer. in_tuser is kind.
// out_ channel: ranked entries of a closed interval, out_tlast on the final one.
// cfg_: write enable, index and data; write only while idle.
// A frame passes the front in steps: accept, the alignment divider, a multiply
// and the hand-over to the queue; a close goes from accept to the hand-over.
// The back then compares occupied slots in turn until the address matches.
// Closing an interval walks the occupied slots once per ranked result
// (reading and comparing each slot, then fetching and presenting it) through the table
// memory read port.
// A small queue between front and back lets each side stall on its own.
// Reset empties the table, closes the interval and restores the registers
// to use_destination 1, top_count 20, interval_seconds 5.
// When the receiver stalls, the current result holds, the queue fills and
// then the input stalls.
module mac_top_talker_ranker import mttr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // kind
  // time_sec, src_addr, dst_addr, frame_len, sampled, rate, zero pad
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tlast,
  // interval_start, rank, mac_address, byte_total, packet_total,
  // table_overflowed
  output logic [183:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  logic        use_dst_r;
  logic [6:0]  top_r;
  logic [15:0] ivl_r;
  logic fv, fr, bv, br;
  cmd_t fc, bc;
  logic [31:0] o_start, o_pkts;
  logic [6:0]  o_rank;
  logic [AW-1:0] o_addr;
  logic [63:0] o_bytes;
  logic o_ovf;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_dst_r <= 1'b1;
      top_r     <= 7'd20;
      ivl_r     <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_DST:  use_dst_r <= cfg_wdata[0];
        CFG_TOP_CNT:  top_r     <= cfg_wdata[6:0];
        CFG_INTERVAL: ivl_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mttr_front u_front (
    .clk, .rst_n, .use_dst(use_dst_r), .ivl_sec(ivl_r),
    .in_valid(in_tvalid), .in_ready(in_tready), .kind(in_tuser[0]),
    .time_sec(in_tdata[31:0]), .src_addr(in_tdata[79:32]),
    .dst_addr(in_tdata[127:80]), .frame_len(in_tdata[143:128]),
    .sampled(in_tdata[144]), .rate_mult(in_tdata[176:145]),
    .cmd_valid(fv), .cmd_ready(fr), .cmd(fc));

  mttr_queue u_queue (
    .clk, .rst_n, .in_valid(fv), .in_ready(fr), .in_cmd(fc),
    .out_valid(bv), .out_ready(br), .out_cmd(bc));

  mttr_back u_back (
    .clk, .rst_n, .top_cnt(top_r), .cmd_valid(bv), .cmd_ready(br), .cmd(bc),
    .out_valid(out_tvalid), .out_ready(out_tready), .o_start, .o_rank,
    .o_addr, .o_bytes, .o_pkts, .o_ovf, .o_last(out_tlast));

  assign out_tdata = {o_ovf, o_pkts, o_bytes, o_addr, o_rank, o_start};
endmodule

// ----- tb/mttr_rank_checker.sv -----
`timescale 1ns / 100ps

module mttr_rank_checker import mttr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [0:0]   in_tuser,
  input  logic [183:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         out_tlast,
  input  logic [183:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           ranks_pending
);

  typedef struct packed {
    logic [31:0]   start;
    logic [6:0]    rank;
    logic [AW-1:0] mac;
    logic [63:0]   bytes;
    logic [31:0]   pkts;
    logic          ovf;
    logic          last;
  } ranked_t;

  ranked_t rank_q[$];

  // predicted table and interval state
  logic [AW-1:0] tab_addr  [TABLE_ENTRIES];
  logic [63:0]   tab_bytes [TABLE_ENTRIES];
  logic [31:0]   tab_pkts  [TABLE_ENTRIES];
  int            occ;
  logic [31:0]   ivl_start;
  logic          ivl_open;
  logic          ovf_seen;
  logic          key_dst;
  logic [6:0]    top_n;
  logic [15:0]   ivl_len;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // rank occupied slots by bytes, lower slot wins ties; then clear
  task automatic close_and_rank();
    bit      taken [TABLE_ENTRIES];
    int      limit;
    int      n;
    int      best;
    ranked_t res;
    limit = (top_n == 0) ? 1 : ((top_n > MAX_RANKED) ? MAX_RANKED : int'(top_n));
    n = (occ < limit) ? occ : limit;
    for (int i = 0; i < TABLE_ENTRIES; i++) taken[i] = 0;
    for (int r = 0; r < n; r++) begin
      best = -1;
      for (int i = 0; i < occ; i++) begin
        if (taken[i]) continue;
        if (best < 0 || tab_bytes[i] > tab_bytes[best]) best = i;
      end
      taken[best] = 1;
      res.start = ivl_start;
      res.rank  = 7'(r + 1);
      res.mac   = tab_addr[best];
      res.bytes = tab_bytes[best];
      res.pkts  = tab_pkts[best];
      res.ovf   = ovf_seen;
      res.last  = (r == n - 1);
      rank_q.push_back(res);
    end
    occ      = 0;
    ovf_seen = 0;
    ivl_open = 0;
  endtask

  task automatic account_frame(input logic [AW-1:0] addr, input logic [15:0] len,
                               input logic smp, input logic [31:0] rate);
    int          slot;
    logic [64:0] bsum;
    logic [32:0] psum;
    slot = -1;
    for (int i = 0; i < occ; i++)
      if (tab_addr[i] == addr) begin
        slot = i;
        break;
      end
    if (slot < 0) begin
      if (occ >= TABLE_ENTRIES) begin
        ovf_seen = 1;
        return;
      end
      slot = occ;
      tab_addr[slot]  = addr;
      tab_bytes[slot] = '0;
      tab_pkts[slot]  = '0;
      occ++;
    end
    bsum = {1'b0, tab_bytes[slot]} + (smp ? 65'(64'(len) * 64'(rate)) : 65'(len));
    psum = {1'b0, tab_pkts[slot]} + (smp ? 33'(rate) : 33'd1);
    tab_bytes[slot] = bsum[64] ? '1 : bsum[63:0];
    tab_pkts[slot]  = psum[32] ? '1 : psum[31:0];
  endtask

  task automatic predict_item();
    logic [31:0] t;
    logic [31:0] ivl;
    logic [31:0] aligned;
    t   = in_tdata[31:0];
    ivl = (ivl_len == 0) ? 32'd1 : 32'(ivl_len);
    if (in_tuser[0]) begin
      if (ivl_open) close_and_rank();
      return;
    end
    aligned = t - (t % ivl);
    if (ivl_open && aligned > ivl_start) close_and_rank();
    if (!ivl_open) begin
      ivl_start = aligned;
      ivl_open  = 1;
    end
    account_frame(key_dst ? in_tdata[127:80] : in_tdata[79:32], in_tdata[143:128],
                  in_tdata[144], in_tdata[176:145]);
  endtask

  task automatic compare_rank();
    ranked_t want;
    if (rank_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result, tdata %h", out_tdata));
      return;
    end
    want = rank_q.pop_front();
    if (out_tdata[31:0] != want.start)
      report_mismatch($sformatf("interval_start %h want %h", out_tdata[31:0], want.start));
    if (out_tdata[38:32] != want.rank)
      report_mismatch($sformatf("rank %0d want %0d", out_tdata[38:32], want.rank));
    if (out_tdata[86:39] != want.mac)
      report_mismatch($sformatf("mac_address %h want %h", out_tdata[86:39], want.mac));
    if (out_tdata[150:87] != want.bytes)
      report_mismatch($sformatf("byte_total %h want %h", out_tdata[150:87], want.bytes));
    if (out_tdata[182:151] != want.pkts)
      report_mismatch($sformatf("packet_total %h want %h", out_tdata[182:151], want.pkts));
    if (out_tdata[183] != want.ovf)
      report_mismatch($sformatf("table_overflowed %b want %b", out_tdata[183], want.ovf));
    if (out_tlast != want.last)
      report_mismatch($sformatf("tlast %b want %b (rank %0d)", out_tlast, want.last,
                                want.rank));
  endtask

  // follow every transfer and register write at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      occ       = 0;
      ivl_start = '0;
      ivl_open  = 0;
      ovf_seen  = 0;
      key_dst   = 1;
      top_n     = 7'd20;
      ivl_len   = 16'd5;
      rank_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_USE_DST:  key_dst = cfg_wdata[0];
          CFG_TOP_CNT:  top_n   = cfg_wdata[6:0];
          CFG_INTERVAL: ivl_len = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) compare_rank();
      if (in_tvalid && in_tready) predict_item();
    end
    ranks_pending = rank_q.size();
  end

endmodule

// ----- tb/tb_mac_top_talker_ranker.sv -----
`timescale 1ns / 100ps

module tb_mac_top_talker_ranker import mttr_pkg::*;;

  localparam int IDLE_LIMIT  = 40000;
  localparam int SETTLE_CYC  = 400;
  localparam int HOLD_CYC    = 3000;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [0:0]   in_tuser;   // kind
  // time_sec, src_addr, dst_addr, frame_len, sampled, rate, zero pad
  logic [183:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         out_tlast;
  // interval_start, rank, mac_address, byte_total, packet_total,
  // table_overflowed
  logic [183:0] out_tdata;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_wdata;
  int           fail_count;
  int           ranks_pending;

  bit           quiet;
  bit           hold_done;
  int           idle_cycles;
  logic [31:0]  now_sec;
  logic [AW-1:0] addr_pool [8];

  mac_top_talker_ranker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mttr_rank_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .ranks_pending(ranks_pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // receiver: random stalls, one long hold-off once results pile up
  initial begin
    out_tready = 1'b0;
    hold_done  = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && ranks_pending >= 10) begin
        hold_done  = 1;
        out_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end
      out_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_mac_top_talker_ranker failed");
      $finish;
    end
  end

  // offer one item and hold it until the transfer; valid stays high after
  task automatic send_item(input logic kind, input logic [31:0] t, input logic [AW-1:0] src,
                           input logic [AW-1:0] dst, input logic [15:0] len,
                           input logic smp, input logic [31:0] rate);
    if (!quiet && $urandom_range(0, 99) < 23) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = {7'd0, rate, smp, len, dst, src, t};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [31:0] t, input logic [AW-1:0] key,
                            input logic [15:0] len, input logic smp,
                            input logic [31:0] rate);
    logic [AW-1:0] other;
    other = AW'({$urandom, $urandom});
    send_item(KIND_FRAME, t, other, key, len, smp, rate);
  endtask

  // drain, settle, then write all three registers
  task automatic write_regs(input logic dst, input logic [15:0] top, input logic [15:0] ivl);
    in_tvalid = 1'b0;
    while (ranks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_USE_DST;  cfg_wdata = 16'(dst); @(negedge clk);
    cfg_index = CFG_TOP_CNT;  cfg_wdata = top;      @(negedge clk);
    cfg_index = CFG_INTERVAL; cfg_wdata = ivl;      @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [AW-1:0] pick_addr();
    if ($urandom_range(0, 99) < 75) return addr_pool[$urandom_range(0, 7)];
    return AW'({$urandom, $urandom});
  endfunction

  // frames keyed on either address: the unused one is random too
  task automatic random_item(input logic [15:0] ivl);
    int          r;
    logic [31:0] rate;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_item(KIND_CLOSE, $urandom, AW'({$urandom, $urandom}), AW'({$urandom, $urandom}),
                16'($urandom), 1'($urandom), $urandom);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70) ;
    else if (r < 85) now_sec = now_sec + $urandom_range(1, 2 * int'(ivl) + 1);
    else if (r < 93) now_sec = now_sec - $urandom_range(0, 3 * int'(ivl));
    else now_sec = $urandom;
    r = $urandom_range(0, 9);
    rate = (r < 2) ? 32'd0 : ((r < 5) ? $urandom : $urandom_range(1, 1000));
    send_item(KIND_FRAME, now_sec, pick_addr(), pick_addr(), 16'($urandom),
              $urandom_range(0, 99) < 30, rate);
  endtask

  task automatic random_phase(input logic dst, input logic [15:0] top,
                              input logic [15:0] ivl, input int n_items, input bit fill);
    write_regs(dst, top, ivl);
    foreach (addr_pool[i]) addr_pool[i] = AW'({$urandom, $urandom});
    now_sec = $urandom;
    if (fill) begin
      // more distinct addresses than the table holds, then close
      for (int k = 0; k < TABLE_ENTRIES + 3; k++)
        send_item(KIND_FRAME, now_sec, {16'(k), $urandom}, {16'(k), $urandom},
                  16'($urandom), 1'b0, 32'd0);
      send_item(KIND_CLOSE, '0, '0, '0, '0, 1'b0, '0);
    end
    repeat (n_items) random_item(ivl == 0 ? 16'd1 : ivl);
    send_item(KIND_CLOSE, '0, '0, '0, '0, 1'b0, '0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_FRAME;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_USE_DST;
    cfg_wdata = '0;
    quiet     = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part with reset settings: keyed on destination, top 20, 5 s
    send_item(KIND_CLOSE, '1, '1, '1, '1, 1'b1, '1);
    send_frame(32'd0, '1, 16'hFFFF, 1'b0, 32'd0);
    send_frame(32'd3, '0, 16'd0, 1'b0, '1);
    send_frame(32'd4, 48'h0000_0000_0001, 16'd100, 1'b1, 32'd0);
    send_frame(32'd4, 48'h8000_0000_0000, 16'hFFFF, 1'b1, '1);
    send_frame(32'd4, 48'h8000_0000_0000, 16'hFFFF, 1'b1, '1);
    send_frame(32'd4, '1, 16'd1, 1'b0, 32'd5);
    send_frame(32'd12, 48'h5555_5555_5555, 16'd64, 1'b0, 32'd0);
    send_frame(32'd7, 48'hAAAA_AAAA_AAAA, 16'd1500, 1'b0, 32'd0);
    send_frame(32'd1, 48'h5555_5555_5555, 16'd9000, 1'b0, 32'd0);
    send_frame(32'hFFFF_FFFF, 48'h0123_4567_89AB, 16'd60, 1'b1, 32'd2);
    send_item(KIND_CLOSE, '1, '1, '1, '1, 1'b1, '1);
    send_item(KIND_CLOSE, '0, '0, '0, '0, 1'b0, '0);
    send_frame(32'd20, 48'h0000_FFFF_0000, 16'd200, 1'b0, 32'd0);
    send_frame(32'd24, 48'h0000_FFFF_0000, 16'd200, 1'b0, 32'd0);
    send_frame(32'd24, 48'hFFFF_0000_FFFF, 16'd400, 1'b0, 32'd0);

    // random phases across register settings
    quiet = 1;
    random_phase(1'b0, 16'd1, 16'd1, 40, 0);
    quiet = 0;
    random_phase(1'b1, 16'd64, 16'd65535, 40, 1);
    random_phase(1'b0, 16'd0, 16'd0, 40, 0);
    random_phase(1'b1, 16'd127, 16'd7, 40, 0);
    random_phase(1'b0, 16'd20, 16'd5, 40, 0);
    random_phase(1'b1, 16'd3, 16'hFFFF, 40, 0);

    // wait for the last rankings, then let the block settle
    in_tvalid = 1'b0;
    while (ranks_pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && ranks_pending == 0)
      $display("tb_mac_top_talker_ranker passed");
    else
      $display("tb_mac_top_talker_ranker failed");
    $finish;
  end

endmodule
